### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the compensation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ESCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define ESCU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/escu_pkg.sv
// Shared types, constants and helper functions of the compensation unit.
package escu_pkg;

  // Field widths of a transfer.
  localparam int RAW_T_W = 20;
  localparam int RAW_P_W = 20;
  localparam int RAW_H_W = 16;
  localparam int TEMP_W  = 24;
  localparam int PRESS_W = 26;
  localparam int HUM_W   = 17;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_LO = 3'd1,
    CFG_PRESS_HI = 3'd2,
    CFG_MIXED    = 3'd3,
    CFG_HUMID    = 3'd4
  } cfg_idx_e;

  // Compensation constants.
  localparam int TC_SCALE      = 5;
  localparam int TC_ROUND      = 128;
  localparam int FINE_P_OFFSET = 128000;
  localparam int PRESS_BASE    = 1048576;
  localparam int PRESS_SCALE   = 3125;
  localparam int FINE_H_OFFSET = 76800;
  localparam int H_ROUND_U     = 16384;
  localparam int H_W_BIAS      = 32768;
  localparam int H_W_OFFSET    = 2097152;
  localparam int H_ROUND_W     = 8192;
  localparam int HUM_CAP       = 419430400;
  localparam int PRESS_MAX     = 67108863;
  localparam logic [63:0] PRESS_BIAS = 64'h0000_8000_0000_0000;

  // Pipeline geometry.
  localparam int DIV_W         = 31;
  localparam int DIVIDEND_W    = 64;
  localparam int DIV_BITS      = 4;
  localparam int DIV_STAGES    = DIVIDEND_W / DIV_BITS;
  localparam int FRONT_STAGES  = 6;
  localparam int PRESS_STAGES  = 12 + DIV_STAGES;
  localparam int HUM_STAGES    = 6;
  localparam int HUM_DELAY     = PRESS_STAGES - HUM_STAGES;
  localparam int PIPE_DEPTH    = FRONT_STAGES + PRESS_STAGES;

  // Unpacked trimming coefficients; signed ones are read through $signed.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } coef_t;

  // Hand-over from the temperature front end to the pressure and humidity paths.
  typedef struct packed {
    logic [TEMP_W-1:0]  tc;
    logic [32:0]        v1;
    logic [31:0]        hv;
    logic [RAW_P_W-1:0] adc_p;
    logic [RAW_H_W-1:0] adc_h;
  } front_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [DIV_W-1:0]      rem;
    logic [DIVIDEND_W-1:0] dq;
    logic [DIV_W-1:0]      md;
    logic                  neg;
    logic                  inv;
  } div_st_t;

  function automatic coef_t unpack_coefs(input logic [47:0] temp_r,
                                         input logic [63:0] plo_r,
                                         input logic [63:0] phi_r,
                                         input logic [47:0] mix_r,
                                         input logic [31:0] hum_r);
    coef_t c;
    c.t1 = temp_r[15:0];
    c.t2 = temp_r[31:16];
    c.t3 = temp_r[47:32];
    c.p1 = plo_r[15:0];
    c.p2 = plo_r[31:16];
    c.p3 = plo_r[47:32];
    c.p4 = plo_r[63:48];
    c.p5 = phi_r[15:0];
    c.p6 = phi_r[31:16];
    c.p7 = phi_r[47:32];
    c.p8 = phi_r[63:48];
    c.p9 = mix_r[15:0];
    c.h1 = mix_r[23:16];
    c.h2 = mix_r[39:24];
    c.h3 = mix_r[47:40];
    c.h4 = hum_r[11:0];
    c.h5 = hum_r[23:12];
    c.h6 = hum_r[31:24];
    return c;
  endfunction

  // DIV_BITS quotient bits of an unsigned restoring division.
  function automatic div_st_t div_step(input div_st_t cur);
    div_st_t     nxt;
    logic [DIV_W:0] trial;
    nxt = cur;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial  = {nxt.rem, nxt.dq[DIVIDEND_W-1]};
      nxt.dq = {nxt.dq[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, nxt.md}) begin
        trial     = trial - {1'b0, nxt.md};
        nxt.dq[0] = 1'b1;
      end
      nxt.rem = trial[DIV_W-1:0];
    end
    return nxt;
  endfunction

endpackage

### rtl/core/environment_sensor_compensation_unit.sv
// Environmental sensor compensation unit: top level with stream ports and valid pipeline.
// A result passes through 34 register stages after the edge that accepts its input transfer,
// 6 in the temperature front end and 28 in the pressure path, 16 of those the divider steps.
// Throughput is one transfer per cycle; a stalled output freezes every stage together.
// rst_ni clears all valid bits and the coefficient registers to zero asynchronously.
`include "assert_macros.svh"

module environment_sensor_compensation_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // temperature sample [19:0], pressure sample [39:20], humidity sample [55:40]
  input  logic [escu_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // temperature_centi [23:0], pressure_q18_8 [49:24], humidity_q7_10 [66:50], zero fill
  output logic [escu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // pressure_invalid [0]
  output logic [0:0]                         m_axis_tuser_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_we_i,
  input  logic [escu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [escu_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  escu_pkg::coef_t              coef;
  escu_pkg::front_t             fr;
  logic [escu_pkg::PIPE_DEPTH-1:0] vld_q;
  logic                         pipe_en;
  logic [escu_pkg::PRESS_W-1:0] pres;
  logic                         pres_inval;
  logic [escu_pkg::TEMP_W-1:0]  tc;
  logic [escu_pkg::HUM_W-1:0]   hum;

  // The whole pipeline advances together whenever the last stage is empty or its
  // result is being taken, so the output register doubles as the hand-over stage.
  assign pipe_en         = !vld_q[escu_pkg::PIPE_DEPTH-1] || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[escu_pkg::PIPE_DEPTH-2:0], s_axis_tvalid_i};
    end
  end

  escu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  // Temperature first: its fine value feeds both later paths of the same item.
  escu_front u_front (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .raw_t_i (s_axis_tdata_i[19:0]),
    .raw_p_i (s_axis_tdata_i[39:20]),
    .raw_h_i (s_axis_tdata_i[55:40]),
    .coef_i  (coef),
    .fr_o    (fr)
  );

  escu_press u_press (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .fr_i    (fr),
    .coef_i  (coef),
    .pres_o  (pres),
    .inval_o (pres_inval)
  );

  // The humidity path is shorter; it delays its result and the temperature so that
  // all fields of one item leave together with the pressure.
  escu_humid u_humid (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .fr_i   (fr),
    .coef_i (coef),
    .tc_o   (tc),
    .hum_o  (hum)
  );

  assign m_axis_tdata_o  = {5'b0, hum, pres, tc};
  assign m_axis_tuser_o  = pres_inval;
  assign m_axis_tvalid_o = vld_q[escu_pkg::PIPE_DEPTH-1];

  // A zero divisor must always force the pressure field to zero.
  `ESCU_ASSERT(a_inval_zero, (m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[49:24] == '0), "invalid pressure not zero")
  // Humidity never leaves its clamped range.
  `ESCU_ASSERT(a_hum_range, (m_axis_tvalid_o |-> m_axis_tdata_o[66:50] <= 17'd102400), "humidity out of range")
  // A stalled pipeline neither gains nor loses items.
  `ESCU_ASSERT(a_stall_hold, (!pipe_en |=> vld_q == $past(vld_q)), "valid bits moved during a stall")
  // Reset empties the pipeline.
  `ESCU_ASSERT_RST(a_rst_empty, (!rst_ni |-> vld_q == '0), "valid bits set during reset")

endmodule

### rtl/core/escu_cfg.sv
// Trimming coefficient registers and their unpacking.
module escu_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [escu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [escu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output escu_pkg::coef_t                coef_o
);

  logic [47:0] temp_q;
  logic [63:0] plo_q;
  logic [63:0] phi_q;
  logic [47:0] mix_q;
  logic [31:0] hum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      plo_q  <= '0;
      phi_q  <= '0;
      mix_q  <= '0;
      hum_q  <= '0;
    end else if (cfg_we_i) begin
      case (escu_pkg::cfg_idx_e'(cfg_idx_i))
        escu_pkg::CFG_TEMP:     temp_q <= cfg_wdata_i[47:0];
        escu_pkg::CFG_PRESS_LO: plo_q  <= cfg_wdata_i;
        escu_pkg::CFG_PRESS_HI: phi_q  <= cfg_wdata_i;
        escu_pkg::CFG_MIXED:    mix_q  <= cfg_wdata_i[47:0];
        escu_pkg::CFG_HUMID:    hum_q  <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign coef_o = escu_pkg::unpack_coefs(temp_q, plo_q, phi_q, mix_q, hum_q);

endmodule

### rtl/core/escu_front.sv
// Temperature compensation front end producing the fine temperature terms.
module escu_front (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [escu_pkg::RAW_T_W-1:0] raw_t_i,
  input  logic [escu_pkg::RAW_P_W-1:0] raw_p_i,
  input  logic [escu_pkg::RAW_H_W-1:0] raw_h_i,
  input  escu_pkg::coef_t              coef_i,
  output escu_pkg::front_t             fr_o
);

  typedef struct packed {
    logic [escu_pkg::RAW_P_W-1:0] adc_p;
    logic [escu_pkg::RAW_H_W-1:0] adc_h;
  } side_t;

  logic [escu_pkg::RAW_T_W-1:0] adc_t_q;
  side_t                         side_q [5];
  logic signed [17:0]            x1_q, x1_d;
  logic signed [16:0]            x2_q, x2_d;
  logic [31:0]                   prod1_q, sq_q;
  logic signed [33:0]            prod1_full, sq_full;
  logic signed [31:0]            a1_q, a1_d, b_q;
  logic signed [31:0]            sqs;
  logic signed [35:0]            b_full;
  logic signed [31:0]            fine_q, fine_d, a2;
  logic [31:0]                   tc_sum;
  escu_pkg::front_t              fr_q, fr_d;

  always_comb begin
    x1_d = $signed({1'b0, adc_t_q[19:3]}) - $signed({1'b0, coef_i.t1, 1'b0});
    x2_d = $signed({1'b0, adc_t_q[19:4]}) - $signed({1'b0, coef_i.t1});
    prod1_full = x1_q * $signed(coef_i.t2);
    sq_full    = x2_q * x2_q;
    a1_d   = $signed(prod1_q) >>> 11;
    sqs    = $signed(sq_q) >>> 12;
    b_full = $signed(sqs[19:0]) * $signed(coef_i.t3);
    a2     = b_q >>> 14;
    fine_d = a1_q + a2;
    tc_sum = fine_q * 32'(escu_pkg::TC_SCALE) + 32'(escu_pkg::TC_ROUND);
    fr_d.tc    = tc_sum[31:8];
    fr_d.v1    = {fine_q[31], fine_q} - 33'(escu_pkg::FINE_P_OFFSET);
    fr_d.hv    = fine_q - 32'(escu_pkg::FINE_H_OFFSET);
    fr_d.adc_p = side_q[4].adc_p;
    fr_d.adc_h = side_q[4].adc_h;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adc_t_q   <= raw_t_i;
      side_q[0] <= '{adc_p: raw_p_i, adc_h: raw_h_i};
      for (int s = 1; s < 5; s++) begin
        side_q[s] <= side_q[s-1];
      end
      x1_q    <= x1_d;
      x2_q    <= x2_d;
      prod1_q <= prod1_full[31:0];
      sq_q    <= sq_full[31:0];
      a1_q    <= a1_d;
      b_q     <= b_full[31:0];
      fine_q  <= fine_d;
      fr_q    <= fr_d;
    end
  end

  assign fr_o = fr_q;

endmodule

### rtl/core/escu_press.sv
// Pressure compensation pipeline with a staged signed 64-bit divider.
module escu_press (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  escu_pkg::front_t             fr_i,
  input  escu_pkg::coef_t              coef_i,
  output logic [escu_pkg::PRESS_W-1:0] pres_o,
  output logic                         inval_o
);

  localparam int DS = escu_pkg::DIV_STAGES;

  // Stage registers.
  logic signed [63:0] vsq_q, vsq_d;
  logic signed [48:0] v1p5_q, v1p5_d, v1p2_q, v1p2_d;
  logic signed [63:0] v2a_q, v1b_q;
  logic signed [48:0] v1p5b_q, v1p2b_q;
  logic signed [63:0] v2_q, v2_d, v1d_q, v1d_d;
  logic signed [63:0] v1e_q, v2b_q;
  logic signed [escu_pkg::DIV_W-1:0] div_q, div2_q;
  logic signed [63:0] num_q, num_d, numx_q;
  logic [escu_pkg::RAW_P_W-1:0] adcp_q [4];
  escu_pkg::div_st_t  dv_q [DS+1];
  escu_pkg::div_st_t  dv_d [DS+1];
  logic signed [63:0] p_q, p_d, p1_q, ps_q, ps_d, c2m_q, pc_q, pc_d, sum_q, sum_d;
  logic [63:0]        m1_q, ppa_q, ppa_d;
  logic [31:0]        ppb_q, ppc_q;
  logic               inv_q [5];
  logic [escu_pkg::PRESS_W-1:0] pres_q, pres_d;

  // Combinational terms.
  logic signed [32:0] v1_s;
  logic signed [65:0] vsq_full;
  logic signed [79:0] v2a_full, v1b_full, c2m_full;
  logic signed [63:0] v1p5_x, v1p2_x, p4_x, v1b_sh;
  logic signed [80:0] v1e_full;
  logic [20:0]        pbase;
  logic signed [76:0] numx_full;
  logic signed [66:0] m1_full;
  logic [63:0]        ppb_full, ppc_full, m2;
  logic signed [63:0] m2_s, c1_s, c2_s, sum_sh, p7_x, pf;

  always_comb begin
    v1_s     = $signed(fr_i.v1);
    vsq_full = v1_s * v1_s;
    vsq_d    = vsq_full[63:0];
    v1p5_d   = v1_s * $signed(coef_i.p5);
    v1p2_d   = v1_s * $signed(coef_i.p2);

    v2a_full = vsq_q * $signed(coef_i.p6);
    v1b_full = vsq_q * $signed(coef_i.p3);

    v1p5_x = v1p5b_q;
    v1p2_x = v1p2b_q;
    p4_x   = $signed(coef_i.p4);
    v1b_sh = v1b_q >>> 8;
    v2_d   = v2a_q + (v1p5_x <<< 17) + (p4_x <<< 35);
    v1d_d  = v1b_sh + (v1p2_x <<< 12) + $signed(escu_pkg::PRESS_BIAS);

    v1e_full = v1d_q * $signed({1'b0, coef_i.p1});

    pbase = 21'(escu_pkg::PRESS_BASE) - {1'b0, adcp_q[3]};
    num_d = $signed({12'b0, pbase, 31'b0}) - v2b_q;

    numx_full = num_q * $signed({1'b0, 12'(escu_pkg::PRESS_SCALE)});

    // Sign and magnitude ahead of the unsigned divider.
    dv_d[0].rem = '0;
    dv_d[0].dq  = numx_q[63] ? (64'd0 - numx_q) : numx_q;
    dv_d[0].md  = div2_q[escu_pkg::DIV_W-1] ? (31'd0 - div2_q) : div2_q;
    dv_d[0].neg = numx_q[63] ^ div2_q[escu_pkg::DIV_W-1];
    dv_d[0].inv = (div2_q == '0);
    for (int s = 0; s < DS; s++) begin
      dv_d[s+1] = escu_pkg::div_step(dv_q[s]);
    end

    p_d = dv_q[DS].neg ? $signed(64'd0 - dv_q[DS].dq) : $signed(dv_q[DS].dq);

    ps_d     = p_q >>> 13;
    m1_full  = $signed(ps_d[50:0]) * $signed(coef_i.p9);
    c2m_full = p_q * $signed(coef_i.p8);

    // Low 64 bits of m1 * ps from three 32-bit partial products.
    ppa_d    = {32'b0, m1_q[31:0]} * {32'b0, ps_q[31:0]};
    ppb_full = {32'b0, m1_q[63:32]} * {32'b0, ps_q[31:0]};
    ppc_full = {32'b0, m1_q[31:0]} * {32'b0, ps_q[63:32]};
    c2_s     = c2m_q >>> 19;
    pc_d     = p1_q + c2_s;

    m2    = ppa_q + {ppb_q + ppc_q, 32'b0};
    m2_s  = m2;
    c1_s  = m2_s >>> 25;
    sum_d = pc_q + c1_s;

    sum_sh = sum_q >>> 8;
    p7_x   = $signed(coef_i.p7);
    pf     = sum_sh + (p7_x <<< 4);
    if (inv_q[3] || pf[63]) begin
      pres_d = '0;
    end else if (pf > 64'(escu_pkg::PRESS_MAX)) begin
      pres_d = escu_pkg::PRESS_W'(escu_pkg::PRESS_MAX);
    end else begin
      pres_d = pf[escu_pkg::PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vsq_q     <= vsq_d;
      v1p5_q    <= v1p5_d;
      v1p2_q    <= v1p2_d;
      adcp_q[0] <= fr_i.adc_p;
      for (int s = 1; s < 4; s++) begin
        adcp_q[s] <= adcp_q[s-1];
      end
      v2a_q   <= v2a_full[63:0];
      v1b_q   <= v1b_full[63:0];
      v1p5b_q <= v1p5_q;
      v1p2b_q <= v1p2_q;
      v2_q    <= v2_d;
      v1d_q   <= v1d_d;
      v1e_q   <= v1e_full[63:0];
      v2b_q   <= v2_q;
      div_q   <= v1e_q[63:33];
      num_q   <= num_d;
      div2_q  <= div_q;
      numx_q  <= numx_full[63:0];
      for (int s = 0; s <= DS; s++) begin
        dv_q[s] <= dv_d[s];
      end
      p_q      <= p_d;
      inv_q[0] <= dv_q[DS].inv;
      p1_q     <= p_q;
      ps_q     <= ps_d;
      m1_q     <= m1_full[63:0];
      c2m_q    <= c2m_full[63:0];
      inv_q[1] <= inv_q[0];
      ppa_q    <= ppa_d;
      ppb_q    <= ppb_full[31:0];
      ppc_q    <= ppc_full[31:0];
      pc_q     <= pc_d;
      inv_q[2] <= inv_q[1];
      sum_q    <= sum_d;
      inv_q[3] <= inv_q[2];
      pres_q   <= pres_d;
      inv_q[4] <= inv_q[3];
    end
  end

  assign pres_o  = pres_q;
  assign inval_o = inv_q[4];

endmodule

### rtl/core/escu_humid.sv
// Humidity compensation pipeline with alignment delay for the temperature result.
module escu_humid (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  escu_pkg::front_t            fr_i,
  input  escu_pkg::coef_t             coef_i,
  output logic [escu_pkg::TEMP_W-1:0] tc_o,
  output logic [escu_pkg::HUM_W-1:0]  hum_o
);

  typedef struct packed {
    logic [escu_pkg::TEMP_W-1:0] tc;
    logic [escu_pkg::HUM_W-1:0]  hum;
  } res_t;

  logic [escu_pkg::TEMP_W-1:0] tc_q [escu_pkg::HUM_STAGES];
  logic [31:0]        u0_q, u0_d, ma_q, mb_q, w0_q, w2_q, w2_d, hv2_q, hv2b_q, hv2c_q;
  logic [31:0]        s2_q, t_q;
  logic signed [31:0] u_q, u_d, u2_q;
  logic [escu_pkg::HUM_W-1:0] hum_d;
  res_t               dly_q [escu_pkg::HUM_DELAY];

  logic signed [31:0] hv_s, h4_x, mas, mbs, mbb, w0s, w1, ws, sv, s2s, ts, hvf;
  logic [31:0]        adch;
  logic signed [43:0] h5p;
  logic signed [39:0] ma_full;
  logic signed [40:0] mb_full, t_full;
  logic signed [63:0] w0_full, hv2_full, s2_full;
  logic signed [47:0] w2_full;

  always_comb begin
    hv_s    = $signed(fr_i.hv);
    adch    = {2'b0, fr_i.adc_h, 14'b0};
    h4_x    = $signed(coef_i.h4);
    h5p     = $signed(coef_i.h5) * hv_s;
    u0_d    = adch - 32'(h4_x <<< 20) - h5p[31:0] + 32'(escu_pkg::H_ROUND_U);
    ma_full = hv_s * $signed(coef_i.h6);
    mb_full = hv_s * $signed({1'b0, coef_i.h3});

    u_d     = $signed(u0_q) >>> 15;
    mas     = $signed(ma_q) >>> 10;
    mbs     = $signed(mb_q) >>> 11;
    mbb     = mbs + escu_pkg::H_W_BIAS;
    w0_full = mas * mbb;

    w0s     = $signed(w0_q) >>> 10;
    w1      = w0s + escu_pkg::H_W_OFFSET;
    w2_full = w1 * $signed(coef_i.h2);
    w2_d    = w2_full[31:0] + 32'(escu_pkg::H_ROUND_W);

    ws       = $signed(w2_q) >>> 14;
    hv2_full = u2_q * ws;

    sv      = $signed(hv2_q) >>> 15;
    s2_full = sv * sv;

    s2s    = $signed(s2_q) >>> 7;
    t_full = s2s * $signed({1'b0, coef_i.h1});

    // Clamp to the valid humidity range before dropping the 12 extra fraction bits.
    ts  = $signed(t_q) >>> 4;
    hvf = $signed(hv2c_q) - ts;
    if (hvf[31]) begin
      hum_d = '0;
    end else if (hvf > escu_pkg::HUM_CAP) begin
      hum_d = escu_pkg::HUM_W'(escu_pkg::HUM_CAP >> 12);
    end else begin
      hum_d = hvf[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tc_q[0] <= fr_i.tc;
      for (int s = 1; s < escu_pkg::HUM_STAGES; s++) begin
        tc_q[s] <= tc_q[s-1];
      end
      u0_q   <= u0_d;
      ma_q   <= ma_full[31:0];
      mb_q   <= mb_full[31:0];
      u_q    <= u_d;
      w0_q   <= w0_full[31:0];
      u2_q   <= u_q;
      w2_q   <= w2_d;
      hv2_q  <= hv2_full[31:0];
      s2_q   <= s2_full[31:0];
      hv2b_q <= hv2_q;
      t_q    <= t_full[31:0];
      hv2c_q <= hv2b_q;
      dly_q[0] <= '{tc: tc_q[escu_pkg::HUM_STAGES-1], hum: hum_d};
      for (int s = 1; s < escu_pkg::HUM_DELAY; s++) begin
        dly_q[s] <= dly_q[s-1];
      end
    end
  end

  assign tc_o  = dly_q[escu_pkg::HUM_DELAY-1].tc;
  assign hum_o = dly_q[escu_pkg::HUM_DELAY-1].hum;

endmodule
